### hdl/frct_pkg.sv
// Shared types and constants of the free-range coalescing table.
// Request and response payload structs, datapath command struct.
// No dependencies.
`default_nettype none
package frct_pkg;

   localparam int ADDR_BITS  = 24;
   localparam int LIMIT_BITS = ADDR_BITS + 1;
   localparam int COUNT_BITS = 7;

   typedef struct packed {
      logic [ADDR_BITS-1:0]  range_base;
      logic [LIMIT_BITS-1:0] range_limit;
   } req_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] hole_count;
      logic [LIMIT_BITS-1:0] free_total;
      logic                  merged;
      logic                  table_full;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic apply;
   } cmd_type;

endpackage
`default_nettype wire

### hdl/frct_dp.sv
// Datapath of the free-range coalescing table: a row of hole cells with
// per-cell compare, shift-insert and merge-shift, plus the free-byte total.
// Depends on frct_pkg.
`default_nettype none
module frct_dp import frct_pkg::*; #(
   parameter int MAX_HOLES = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire req_type req_data,
   output rsp_type      rsp_data
);

   localparam int CNT_W = $clog2(MAX_HOLES + 1);
   localparam logic [LIMIT_BITS-1:0] MEM_SIZE = LIMIT_BITS'(1) << ADDR_BITS;

   logic [ADDR_BITS-1:0]  base_ff  [MAX_HOLES];
   logic [LIMIT_BITS-1:0] limit_ff [MAX_HOLES];
   logic [CNT_W-1:0]      used_ff;
   logic [LIMIT_BITS-1:0] total_ff;
   logic [ADDR_BITS-1:0]  b_ff;
   logic [LIMIT_BITS-1:0] l_ff;
   logic                  ok_ff, left_ff, right_ff;
   logic [MAX_HOLES-1:0]  le_ff, lcand_ff;
   rsp_type               rsp_ff;

   logic [MAX_HOLES-1:0]  le_in, lcand_in, rcand;
   logic                  ok_in;
   logic                  full, do_ins;
   logic [CNT_W-1:0]      used_in;
   logic [LIMIT_BITS:0]   sum;
   logic [LIMIT_BITS-1:0] total_in;

   assign ok_in = (req_data.range_limit > {1'b0, req_data.range_base}) &&
                  (req_data.range_limit <= MEM_SIZE);

   // The table is sorted, so le_in is a run of ones from cell 0 up to the
   // last hole whose base is not above the new base.
   always_comb begin
      for (int k = 0; k < MAX_HOLES; k++) begin
         le_in[k] = (CNT_W'(k) < used_ff) && (base_ff[k] <= b_ff);
      end
      for (int k = 0; k < MAX_HOLES; k++) begin
         lcand_in[k] = le_in[k] && ((k == MAX_HOLES - 1) ? 1'b1 : !le_in[(k + 1) % MAX_HOLES])
                       && (limit_ff[k] == {1'b0, b_ff});
         rcand[k] = (CNT_W'(k) < used_ff) && !le_in[k]
                    && ((k == 0) ? 1'b1 : le_in[(k + MAX_HOLES - 1) % MAX_HOLES])
                    && (base_ff[k] == l_ff[ADDR_BITS-1:0]) && !l_ff[ADDR_BITS];
      end
   end

   assign full   = ok_ff && !left_ff && !right_ff && (used_ff == CNT_W'(MAX_HOLES));
   assign do_ins = ok_ff && !left_ff && !right_ff && !full;

   always_comb begin
      used_in = used_ff;
      if (ok_ff && left_ff && right_ff) used_in = used_ff - CNT_W'(1);
      else if (do_ins)                  used_in = used_ff + CNT_W'(1);
   end

   assign sum      = {1'b0, total_ff} + {1'b0, (l_ff - {1'b0, b_ff})};
   assign total_in = (!ok_ff || full) ? total_ff :
                     (sum > {1'b0, MEM_SIZE}) ? MEM_SIZE : sum[LIMIT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         b_ff  <= req_data.range_base;
         l_ff  <= req_data.range_limit;
         ok_ff <= ok_in;
      end
      if (cmd.eval) begin
         le_ff    <= le_in;
         lcand_ff <= lcand_in;
         left_ff  <= |lcand_in;
         right_ff <= |rcand;
      end
      if (cmd.apply) begin
         for (int k = 0; k < MAX_HOLES; k++) begin
            if (ok_ff && left_ff && right_ff) begin
               if (k < MAX_HOLES - 1) begin
                  if (lcand_ff[k]) limit_ff[k] <= limit_ff[(k + 1) % MAX_HOLES];
                  else if (!le_ff[k]) begin
                     base_ff[k]  <= base_ff[(k + 1) % MAX_HOLES];
                     limit_ff[k] <= limit_ff[(k + 1) % MAX_HOLES];
                  end
               end
            end else if (ok_ff && left_ff) begin
               if (lcand_ff[k]) limit_ff[k] <= l_ff;
            end else if (ok_ff && right_ff) begin
               // The first cell above the run is the right neighbor.
               if (!le_ff[k] && ((k == 0) || le_ff[(k + MAX_HOLES - 1) % MAX_HOLES]))
                  base_ff[k] <= b_ff;
            end else if (do_ins && !le_ff[k]) begin
               if ((k == 0) || le_ff[(k + MAX_HOLES - 1) % MAX_HOLES]) begin
                  base_ff[k]  <= b_ff;
                  limit_ff[k] <= l_ff;
               end else begin
                  base_ff[k]  <= base_ff[(k + MAX_HOLES - 1) % MAX_HOLES];
                  limit_ff[k] <= limit_ff[(k + MAX_HOLES - 1) % MAX_HOLES];
               end
            end
         end
         rsp_ff.hole_count <= COUNT_BITS'(used_in);
         rsp_ff.free_total <= total_in;
         rsp_ff.merged     <= ok_ff && (left_ff || right_ff);
         rsp_ff.table_full <= full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         total_ff <= '0;
      end else if (cmd.apply) begin
         used_ff  <= used_in;
         total_ff <= total_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

### hdl/frct_ctrl.sv
// Controller of the free-range coalescing table: sequences load, compare
// and update, and owns the request and response handshakes.
// Depends on frct_pkg.
`default_nettype none
module frct_ctrl import frct_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output cmd_type   cmd
);

   typedef enum logic [1:0] {IDLE, EVAL, APPLY} state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

   assign cmd.load  = (state_ff == IDLE) && req_valid;
   assign cmd.eval  = (state_ff == EVAL);
   assign cmd.apply = (state_ff == APPLY) && rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A new response replaces one that is taken in the same cycle.
         if ((state_ff == APPLY) && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            IDLE: begin
               if (req_valid) state_ff <= EVAL;
            end
            EVAL: begin
               state_ff <= APPLY;
            end
            APPLY: begin
               // Hold the update until the response register can take it.
               if (rsp_free) state_ff <= IDLE;
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == EVAL))
      else $error("accepted request did not start evaluation");

   a_apply_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == APPLY && rsp_valid_ff && rsp_stall) |=> (state_ff == APPLY))
      else $error("update went ahead over a pending response");

   a_rsp_from_apply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == APPLY))
      else $error("response raised outside the update step");

endmodule
`default_nettype wire

### hdl/free_range_coalescing_table.sv
// Top level of the free-range coalescing table: controller plus datapath.
// Depends on frct_pkg, frct_ctrl and frct_dp.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  req_data (range_base, range_limit)
//   rsp_      out        rsp_valid / rsp_stall  rsp_data (hole_count, free_total,
//                                                         merged, table_full)
//
// Each request runs through load, a compare of all holes at once, and
// one update of the hole cells (shift-insert, merge-shift or in-place edit).
// The response register lets a new request start while a response waits;
// the update step holds only if the previous response has not been taken.
// Synchronous reset empties the table and clears the free total at once.
`default_nettype none
module free_range_coalescing_table import frct_pkg::*; #(
   parameter int MAX_HOLES = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   cmd_type cmd;

   frct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   frct_dp #(.MAX_HOLES(MAX_HOLES)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire
